// ----- hdl/cts_pkg.sv -----
package cts_pkg;

	// Default sizes of the code and of the name in front of the hash mark.
	localparam int SUFFIX_LEN_DEF = 8;
	localparam int NAME_MAX_DEF   = 8;

	// Result form codes.
	localparam logic [1:0] FORM_NONE = 2'd0;
	localparam logic [1:0] FORM_HASH = 2'd1;
	localparam logic [1:0] FORM_BARE = 2'd2;

	// ASCII characters the scanner looks at.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_2     = 8'h32;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_8     = 8'h38;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UI    = 8'h49;
	localparam logic [7:0] CH_UO    = 8'h4F;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	// Classification of one text character.
	typedef struct packed {
		logic [7:0] upper;       // character with lower case folded to upper
		logic [7:0] norm_char;   // normalized base32 character, zero if none
		logic       suffix_ok;   // character is a code character
		logic       sep;         // space or dash
		logic       hash_mark;   // the hash mark
		logic       name_ok;     // letter or digit
	} char_class_t;

endpackage

// ----- hdl/cts_char_class.sv -----
module cts_char_class
	import cts_pkg::*;
(
	input  logic [7:0]  text_byte,
	output char_class_t cls
);

	logic [7:0] up;
	logic [7:0] norm;

	// Fold lower case, then map the look-alike digits onto letters.
	always_comb begin
		up = text_byte;
		if (text_byte >= CH_LA && text_byte <= CH_LZ) begin
			up = text_byte - CASE_GAP;
		end
		norm = 8'd0;
		if (up == CH_0) begin
			norm = CH_UO;
		end else if (up == CH_1) begin
			norm = CH_UI;
		end else if (up == CH_8) begin
			norm = CH_UB;
		end else if ((up >= CH_UA && up <= CH_UZ) || (up >= CH_2 && up <= CH_7)) begin
			norm = up;
		end
	end

	// Pack the classification for the scanner.
	always_comb begin
		cls.upper     = up;
		cls.norm_char = norm;
		cls.suffix_ok = (norm != 8'd0);
		cls.sep       = (text_byte == CH_DASH) || (text_byte == CH_SPACE);
		cls.hash_mark = (text_byte == CH_HASH);
		cls.name_ok   = (up >= CH_UA && up <= CH_UZ) || (up >= CH_0 && up <= CH_9);
	end

endmodule

// ----- hdl/code_token_scanner.sv -----
// Code token scanner.
// The text channel carries one nonzero ASCII character per beat on text_byte,
// with last set on the final character of a text. The result channel carries
// one beat per text: found, form (none, hash or bare), the normalized code in
// suffix_chars and the upper-cased name in name_chars with its name_length.
// Both channels move a beat at a clock edge where valid is high and stall is
// low. A character is taken into the input register and from there updates
// the match state; a last character also loads the result register, where
// its result is offered until it moves with result_stall low.
// Throughput is one character per clock; only the result register limits it,
// and only a last character waits for that register to be free.
// While result_stall is high the result holds, and characters that are not
// the last of a text keep flowing; the next last character waits in the input
// register, and text_stall rises behind it.
// Reset clears all match state and both valid flags. After each result the
// match state returns to its reset value, so the next character starts a new
// text.
module code_token_scanner
	import cts_pkg::*;
#(
	parameter int SUFFIX_LEN = SUFFIX_LEN_DEF,
	parameter int NAME_MAX   = NAME_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        found,
	output logic [1:0]  form,
	output logic [63:0] suffix_chars,
	output logic [63:0] name_chars,
	output logic [3:0]  name_length
);

	localparam int SFX_W = 8 * SUFFIX_LEN;
	localparam int NAM_W = 8 * NAME_MAX;
	localparam int HCW   = $clog2(SUFFIX_LEN + 1);
	localparam int RLW   = $clog2(SUFFIX_LEN + 2);
	localparam int NCW   = $clog2(NAME_MAX + 1);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Match state.
	logic [NAM_W-1:0] recent_q,    recent_d;
	logic [NCW-1:0]   trail_q,     trail_d;
	logic             active_q,    active_d;
	logic [HCW-1:0]   hcnt_q,      hcnt_d;
	logic [SFX_W-1:0] hbuf_q,      hbuf_d;
	logic [NAM_W-1:0] hname_q,     hname_d;
	logic [NCW-1:0]   hncnt_q,     hncnt_d;
	logic [RLW-1:0]   run_len_q,   run_len_d;
	logic [SFX_W-1:0] run_buf_q,   run_buf_d;
	logic             hmf_q,       hmf_d;
	logic             bmf_q,       bmf_d;
	logic [SFX_W-1:0] kept_sfx_q,  kept_sfx_d;
	logic [SFX_W-1:0] kept_bare_q, kept_bare_d;
	logic [NAM_W-1:0] kept_name_q, kept_name_d;
	logic [NCW-1:0]   kept_ncnt_q, kept_ncnt_d;

	logic             take;
	logic [NCW+2:0]   name_shift;
	logic [NAM_W-1:0] name_al;
	logic             out_free;
	logic             consume;
	logic             emit;
	char_class_t      cls;

	cts_char_class u_class (
		.text_byte (byte_s1),
		.cls       (cls)
	);

	// Handshake: a last character needs a free result register.
	assign out_free   = !result_valid || !result_stall;
	assign consume    = valid_s1 && (!last_s1 || out_free);
	assign emit       = consume && last_s1;
	assign text_stall = valid_s1 && !consume;

	// Next match state for the character in the input register.
	always_comb begin
		recent_d    = recent_q;
		trail_d     = trail_q;
		active_d    = active_q;
		hcnt_d      = hcnt_q;
		hbuf_d      = hbuf_q;
		hname_d     = hname_q;
		hncnt_d     = hncnt_q;
		run_len_d   = run_len_q;
		run_buf_d   = run_buf_q;
		hmf_d       = hmf_q;
		bmf_d       = bmf_q;
		kept_sfx_d  = kept_sfx_q;
		kept_bare_d = kept_bare_q;
		kept_name_d = kept_name_q;
		kept_ncnt_d = kept_ncnt_q;
		take        = 1'b0;

		// Hash form: collect the code after a hash mark, skipping separators.
		if (!hmf_q) begin
			if (active_q) begin
				if (hcnt_q == HCW'(SUFFIX_LEN)) begin
					if (cls.suffix_ok) begin
						active_d = 1'b0;
					end else begin
						take = 1'b1;
					end
				end else if (cls.sep) begin
					active_d = active_q;
				end else if (cls.suffix_ok) begin
					hbuf_d = SFX_W'({hbuf_q, cls.norm_char});
					hcnt_d = hcnt_q + 1'b1;
				end else begin
					active_d = 1'b0;
				end
			end
			if (!take && cls.hash_mark) begin
				active_d = 1'b1;
				hcnt_d   = '0;
				hbuf_d   = '0;
				hname_d  = recent_q;
				hncnt_d  = trail_q;
			end
			if (last_s1 && !take && active_d && hcnt_d == HCW'(SUFFIX_LEN)) begin
				take = 1'b1;
			end
			if (take) begin
				hmf_d       = 1'b1;
				active_d    = 1'b0;
				kept_sfx_d  = hbuf_d;
				kept_name_d = hname_d;
				kept_ncnt_d = hncnt_d;
			end
		end

		// Bare form: runs of code characters with no separators.
		if (cls.suffix_ok) begin
			run_buf_d = SFX_W'({run_buf_q, cls.norm_char});
			if (run_len_q <= RLW'(SUFFIX_LEN)) begin
				run_len_d = run_len_q + 1'b1;
			end
			if (last_s1 && run_len_d == RLW'(SUFFIX_LEN) && !bmf_q) begin
				bmf_d       = 1'b1;
				kept_bare_d = run_buf_d;
			end
		end else begin
			if (run_len_q == RLW'(SUFFIX_LEN) && !bmf_q) begin
				bmf_d       = 1'b1;
				kept_bare_d = run_buf_q;
			end
			run_len_d = '0;
			run_buf_d = '0;
		end

		// Name tracker: trailing letters and digits, upper-cased.
		if (cls.name_ok) begin
			recent_d = NAM_W'({recent_q, cls.upper});
			if (trail_q < NCW'(NAME_MAX)) begin
				trail_d = trail_q + 1'b1;
			end
		end else begin
			recent_d = '0;
			trail_d  = '0;
		end
	end

	// Left-align the kept name by its length.
	assign name_shift = {NCW'(NAME_MAX) - kept_ncnt_d, 3'b000};
	assign name_al    = kept_name_d << name_shift;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last;
		end
	end

	// Match state; a last character returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q    <= '0;
			trail_q     <= '0;
			active_q    <= 1'b0;
			hcnt_q      <= '0;
			hbuf_q      <= '0;
			hname_q     <= '0;
			hncnt_q     <= '0;
			run_len_q   <= '0;
			run_buf_q   <= '0;
			hmf_q       <= 1'b0;
			bmf_q       <= 1'b0;
			kept_sfx_q  <= '0;
			kept_bare_q <= '0;
			kept_name_q <= '0;
			kept_ncnt_q <= '0;
		end else if (emit) begin
			recent_q    <= '0;
			trail_q     <= '0;
			active_q    <= 1'b0;
			hcnt_q      <= '0;
			hbuf_q      <= '0;
			hname_q     <= '0;
			hncnt_q     <= '0;
			run_len_q   <= '0;
			run_buf_q   <= '0;
			hmf_q       <= 1'b0;
			bmf_q       <= 1'b0;
			kept_sfx_q  <= '0;
			kept_bare_q <= '0;
			kept_name_q <= '0;
			kept_ncnt_q <= '0;
		end else if (consume) begin
			recent_q    <= recent_d;
			trail_q     <= trail_d;
			active_q    <= active_d;
			hcnt_q      <= hcnt_d;
			hbuf_q      <= hbuf_d;
			hname_q     <= hname_d;
			hncnt_q     <= hncnt_d;
			run_len_q   <= run_len_d;
			run_buf_q   <= run_buf_d;
			hmf_q       <= hmf_d;
			bmf_q       <= bmf_d;
			kept_sfx_q  <= kept_sfx_d;
			kept_bare_q <= kept_bare_d;
			kept_name_q <= kept_name_d;
			kept_ncnt_q <= kept_ncnt_d;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// Result register payload; the hash form wins over the bare form.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (hmf_d) begin
				found        <= 1'b1;
				form         <= FORM_HASH;
				suffix_chars <= 64'(kept_sfx_d) << (64 - SFX_W);
				name_chars   <= 64'(name_al) << (64 - NAM_W);
				name_length  <= 4'(kept_ncnt_d);
			end else if (bmf_d) begin
				found        <= 1'b1;
				form         <= FORM_BARE;
				suffix_chars <= 64'(kept_bare_d) << (64 - SFX_W);
				name_chars   <= 64'd0;
				name_length  <= 4'd0;
			end else begin
				found        <= 1'b0;
				form         <= FORM_NONE;
				suffix_chars <= 64'd0;
				name_chars   <= 64'd0;
				name_length  <= 4'd0;
			end
		end
	end

endmodule
